[rtl/core/cfp_pkg.sv]
// Shared types and constants for the command frame parser.
// Depends on nothing; every other file of the block imports it.
package cfp_pkg;

   localparam int unsigned FRAME_LEN    = 13;
   localparam int unsigned SUM_LEN      = 12;
   localparam int unsigned QUEUE_DEPTH  = 2;

   localparam logic [3:0] CHECKSUM_INDEX = 4'(SUM_LEN);

   localparam logic [7:0] SYNC_BYTE    = 8'h43;
   localparam logic [7:0] HDR_BYTE1    = 8'h63;
   localparam logic [7:0] HDR_BYTE2    = 8'h0c;
   localparam logic [7:0] CMD_TRACK    = 8'h02;
   localparam logic [7:0] CMD_OFFSET   = 8'h04;
   localparam logic [7:0] TRACK_ON_VAL = 8'h01;

   localparam logic [2:0] ST_TRACK_ON  = 3'd0;
   localparam logic [2:0] ST_TRACK_OFF = 3'd1;
   localparam logic [2:0] ST_OFFSETS   = 3'd2;
   localparam logic [2:0] ST_IGNORED   = 3'd3;
   localparam logic [2:0] ST_REJECTED  = 3'd4;

   // One completed frame, classified by the front end.
   typedef struct packed {
      logic               frame_ok;
      logic [7:0]         command_code;
      logic               track_arg_on;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
   } job_type;

endpackage

[rtl/core/cfp_channels_if.sv]
// Request and response channel interfaces of the command frame parser.
// Depends on cfp_pkg.
interface cfp_req_if import cfp_pkg::*; ;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfp_rsp_if import cfp_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [2:0]         frame_status;
   logic [7:0]         command_code;
   logic               tracking_on;
   logic signed [31:0] offset_x;
   logic signed [31:0] offset_y;
   logic               offset_new;

   modport source (output valid, output frame_status, output command_code,
                   output tracking_on, output offset_x, output offset_y,
                   output offset_new, input ready);
   modport sink   (input valid, input frame_status, input command_code,
                   input tracking_on, input offset_x, input offset_y,
                   input offset_new, output ready);
endinterface

[rtl/core/cfp_front.sv]
// Front end: sync hunt, frame collection and frame checks.
// Depends on cfp_pkg and cfp_req_if; pushes one job per completed frame.
module cfp_front import cfp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   cfp_req_if.sink      req_chan,
   output logic         job_push,
   output job_type      job_data,
   input  logic         job_full
);

   logic [3:0] count_ff, count_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] store_ff [SUM_LEN];
   logic       accept;
   logic       at_checksum;
   logic       store_we;

   assign at_checksum    = (count_ff == CHECKSUM_INDEX);
   assign req_chan.ready = !at_checksum || !job_full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      store_we = 1'b0;
      job_push = 1'b0;
      if (accept) begin
         if (count_ff == 4'd0) begin
            // hunt: drop anything but sync
            if (req_chan.rx_byte == SYNC_BYTE) begin
               store_we = 1'b1;
               sum_in   = req_chan.rx_byte;
               count_in = 4'd1;
            end
         end else if (!at_checksum) begin
            store_we = 1'b1;
            sum_in   = sum_ff + req_chan.rx_byte;
            count_in = count_ff + 4'd1;
         end else begin
            job_push = 1'b1;
            sum_in   = 8'd0;
            count_in = 4'd0;
         end
      end
   end

   always_comb begin
      job_data.frame_ok     = (req_chan.rx_byte == sum_ff) &&
                              (store_ff[1] == HDR_BYTE1) &&
                              (store_ff[2] == HDR_BYTE2);
      job_data.command_code = store_ff[3];
      job_data.track_arg_on = (store_ff[4] == TRACK_ON_VAL);
      job_data.offset_x     = {store_ff[7], store_ff[6], store_ff[5], store_ff[4]};
      job_data.offset_y     = {store_ff[11], store_ff[10], store_ff[9], store_ff[8]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
         sum_ff   <= 8'd0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[count_ff] <= req_chan.rx_byte;
      end
   end

endmodule

[rtl/core/cfp_queue.sv]
// Short job queue between front end and back end.
// Depends on cfp_pkg for the job type.
module cfp_queue import cfp_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output job_type pop_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/cfp_back.sv]
// Back end: executes frame jobs, holds tracking and offset state, drives results.
// Depends on cfp_pkg and cfp_rsp_if.
module cfp_back import cfp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job_data,
   output logic    job_pop,
   cfp_rsp_if.source rsp_chan
);

   logic               tracking_ff, tracking_in;
   logic signed [31:0] held_x_ff, held_x_in;
   logic signed [31:0] held_y_ff, held_y_in;
   logic               out_valid_ff;
   logic [2:0]         status_ff, status_in;
   logic [7:0]         cmd_ff;
   logic               fresh_ff, fresh_in;

   // take a job whenever the result register is free or being drained
   assign job_pop = job_valid && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      tracking_in = tracking_ff;
      held_x_in   = held_x_ff;
      held_y_in   = held_y_ff;
      fresh_in    = 1'b0;
      status_in   = ST_REJECTED;
      if (job_data.frame_ok) begin
         if (job_data.command_code == CMD_TRACK) begin
            tracking_in = job_data.track_arg_on;
            status_in   = job_data.track_arg_on ? ST_TRACK_ON : ST_TRACK_OFF;
         end else if (job_data.command_code == CMD_OFFSET) begin
            held_x_in = job_data.offset_x;
            held_y_in = job_data.offset_y;
            fresh_in  = 1'b1;
            status_in = ST_OFFSETS;
         end else begin
            status_in = ST_IGNORED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_ff  <= 1'b0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (job_pop) begin
            tracking_ff  <= tracking_in;
            held_x_ff    <= held_x_in;
            held_y_ff    <= held_y_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         status_ff <= status_in;
         cmd_ff    <= job_data.command_code;
         fresh_ff  <= fresh_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.frame_status = status_ff;
   assign rsp_chan.command_code = cmd_ff;
   assign rsp_chan.tracking_on  = tracking_ff;
   assign rsp_chan.offset_x     = held_x_ff;
   assign rsp_chan.offset_y     = held_y_ff;
   assign rsp_chan.offset_new   = fresh_ff;

endmodule

[rtl/core/command_frame_parser_top.sv]
// Top level of the command frame parser: front end, job queue and back end.
// Depends on cfp_pkg, cfp_req_if/cfp_rsp_if, cfp_front, cfp_queue and cfp_back.
//
// The parser takes one received serial byte per request and hunts for the
// sync byte 0x43. From there it collects a 13-byte frame (sync, 0x63, 0x0c,
// command, eight argument bytes, checksum) and emits exactly one response
// per completed frame; bytes outside a frame produce nothing. A frame whose
// checksum (8-bit sum of bytes 0..11) or header bytes are wrong is reported
// as rejected and hunting resumes at the next byte. Command 0x02 sets
// tracking on when byte 4 is 0x01 and off otherwise; command 0x04 loads the
// little-endian signed X (bytes 4..7) and Y (bytes 8..11) offsets; any other
// command is reported as ignored. Every response carries the current
// tracking flag and stored offsets. Throughput is one byte per clock: the
// front end accepts a byte every cycle, and only the checksum byte can stall,
// when the job queue between front and back end is full. The queue is written
// at the edge that accepts a frame's checksum byte; the back end's result
// register loads from it once free or being drained and holds the response
// until taken. No clearing pass runs after reset.
module command_frame_parser_top import cfp_pkg::*; #(
   parameter int unsigned JOB_QUEUE_DEPTH = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   cfp_req_if.sink    req_chan,
   cfp_rsp_if.source  rsp_chan
);

   logic    job_push;
   job_type job_in;
   logic    job_full;
   logic    job_pop;
   logic    job_valid;
   job_type job_out;

   // collect and classify frames
   cfp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .job_push (job_push),
      .job_data (job_in),
      .job_full (job_full)
   );

   // decouple: front keeps hunting while a result waits downstream
   cfp_queue #(
      .DEPTH (JOB_QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .not_empty (job_valid),
      .pop_data  (job_out)
   );

   // execute commands and hold the result until accepted
   cfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_out),
      .job_pop   (job_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
